>>> hw/rtl/joint_bind_bounds_accumulator_macros.svh
// assertion macros for the joint bounding box accumulator
// sampled on i_clk, disabled while i_rst_n is low; no other dependencies
`ifndef JOINT_BIND_BOUNDS_ACCUMULATOR_MACROS_SVH
`define JOINT_BIND_BOUNDS_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define JBBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JBBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/jbba_pkg.sv
// shared constants and types for the joint bounding box accumulator
// no dependencies
`timescale 1ns / 1ps

package jbba_pkg;

    localparam int JOINTS_MAX_DEF = 256;
    localparam int COORD_BITS_DEF = 24;

    localparam int JOINT_W    = 16;
    localparam int WEIGHT_W   = 16;
    localparam int COUNT_W    = 9;
    localparam int LIMIT_W    = JOINT_W + 1;
    localparam int INFLUENCES = 4;
    localparam int INFL_W     = 2;

    localparam logic [COUNT_W-1:0] JOINT_COUNT_RESET = 9'd256;

    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WORK
    } t_state;

endpackage

>>> hw/rtl/jbba_in_if.sv
// input channel: vertex or read beat with valid/ready
// depends on jbba_pkg
`timescale 1ns / 1ps

interface jbba_in_if #(
    parameter int COORD_BITS = jbba_pkg::COORD_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic signed [COORD_BITS-1:0]        pos_x;
    logic signed [COORD_BITS-1:0]        pos_y;
    logic signed [COORD_BITS-1:0]        pos_z;
    logic        [jbba_pkg::JOINT_W-1:0] joint_a;
    logic        [jbba_pkg::JOINT_W-1:0] joint_b;
    logic        [jbba_pkg::JOINT_W-1:0] joint_c;
    logic        [jbba_pkg::JOINT_W-1:0] joint_d;
    logic signed [jbba_pkg::WEIGHT_W-1:0] weight_a;
    logic signed [jbba_pkg::WEIGHT_W-1:0] weight_b;
    logic signed [jbba_pkg::WEIGHT_W-1:0] weight_c;
    logic signed [jbba_pkg::WEIGHT_W-1:0] weight_d;

    modport source (
        output valid, mode, pos_x, pos_y, pos_z,
        output joint_a, joint_b, joint_c, joint_d,
        output weight_a, weight_b, weight_c, weight_d,
        input  ready
    );

    modport sink (
        input  valid, mode, pos_x, pos_y, pos_z,
        input  joint_a, joint_b, joint_c, joint_d,
        input  weight_a, weight_b, weight_c, weight_d,
        output ready
    );
endinterface

>>> hw/rtl/jbba_out_if.sv
// output channel: one box beat per read, valid/ready
// depends on jbba_pkg
`timescale 1ns / 1ps

interface jbba_out_if #(
    parameter int COORD_BITS = jbba_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         box_valid;
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_z;

    modport source (
        output valid, box_valid, min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );

    modport sink (
        input  valid, box_valid, min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

>>> hw/rtl/jbba_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module jbba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/joint_bind_bounds_accumulator.sv
// per-joint bounding box accumulator, top level
// depends on jbba_pkg, jbba_in_if, jbba_out_if, jbba_ram and the macros header
`timescale 1ns / 1ps

`include "joint_bind_bounds_accumulator_macros.svh"

// Boxes live in one simple dual-port joint store (one read, one write a cycle,
// registered read). A vertex beat issues each influence in turn, counting or
// not, but only a counting influence reads and writes the store; the read of
// one influence overlaps the write-back of the one before, with forwarding
// when both hit the same joint. A read beat is issued once the output register
// is free, and its box passes the update stage into the output register.
// After reset the block clears every store entry before it takes its first
// beat; joint_count writes are taken throughout.
module joint_bind_bounds_accumulator #(
    parameter int JOINTS_MAX = jbba_pkg::JOINTS_MAX_DEF,
    parameter int COORD_BITS = jbba_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jbba_pkg::COUNT_W-1:0]     i_cfg_wdata,
    jbba_in_if.sink                          i_in,
    jbba_out_if.source                       o_out
);

    localparam int IDX_W = (JOINTS_MAX > 1) ? $clog2(JOINTS_MAX) : 1;
    localparam int LW    = jbba_pkg::LIMIT_W;
    localparam logic [LW-1:0] STORE_LIM = LW'(JOINTS_MAX);

    typedef struct packed {
        logic                         filled;
        logic signed [COORD_BITS-1:0] lo_x;
        logic signed [COORD_BITS-1:0] lo_y;
        logic signed [COORD_BITS-1:0] lo_z;
        logic signed [COORD_BITS-1:0] hi_x;
        logic signed [COORD_BITS-1:0] hi_y;
        logic signed [COORD_BITS-1:0] hi_z;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    jbba_pkg::t_state r_state, n_state;

    logic [jbba_pkg::COUNT_W-1:0]  r_joint_count;
    logic [IDX_W-1:0]              r_clr_idx;
    logic [jbba_pkg::INFL_W-1:0]   r_k;

    logic                          r_mode;
    logic signed [COORD_BITS-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic [jbba_pkg::JOINT_W-1:0]  r_joint  [jbba_pkg::INFLUENCES];
    logic [jbba_pkg::WEIGHT_W-1:0] r_weight [jbba_pkg::INFLUENCES];

    logic                          r_s1_valid;
    logic                          r_s1_read;
    logic                          r_s1_hit;
    logic [IDX_W-1:0]              r_s1_addr;
    logic signed [COORD_BITS-1:0]  r_s1_x, r_s1_y, r_s1_z;

    logic                          r_fwd_valid;
    logic [IDX_W-1:0]              r_fwd_addr;
    t_entry                        r_fwd_data;

    logic                          r_out_valid;
    t_entry                        r_out;

    logic                          clr_active;
    logic                          clr_last;
    logic                          in_fire;
    logic                          out_free;
    logic                          issue_fire;
    logic                          issue_last;

    logic [jbba_pkg::JOINT_W-1:0]  sel_joint;
    logic [jbba_pkg::WEIGHT_W-1:0] sel_weight;
    logic [LW-1:0]                 limit;
    logic                          weight_pos;
    logic                          acc_take;
    logic                          store_hit;

    logic [ENTRY_W-1:0]            ram_rdata;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [ENTRY_W-1:0]            ram_wdata;
    logic                          ram_re;

    logic                          fwd_hit;
    t_entry                        cur;
    t_entry                        s1_new;
    logic                          s1_wr;
    t_entry                        out_next;

    // joint count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count <= jbba_pkg::JOINT_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_joint_count <= i_cfg_wdata;
        end
    end

    // issue stage selection
    assign sel_joint  = r_joint[r_k];
    assign sel_weight = r_weight[r_k];
    assign limit      = (LW'(r_joint_count) > STORE_LIM) ? STORE_LIM : LW'(r_joint_count);
    assign weight_pos = !sel_weight[jbba_pkg::WEIGHT_W-1] && (sel_weight != '0);
    assign acc_take   = weight_pos && (LW'(sel_joint) < limit);
    assign store_hit  = LW'(sel_joint) < STORE_LIM;
    assign out_free   = !r_out_valid && !(r_s1_valid && r_s1_read);
    assign clr_last   = (r_clr_idx == IDX_W'(JOINTS_MAX - 1));

    // state machine: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jbba_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = jbba_pkg::ST_IDLE;
                end
            end
            jbba_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = jbba_pkg::ST_WORK;
                end
            end
            jbba_pkg::ST_WORK: begin
                if (issue_fire && issue_last && !i_in.valid) begin
                    n_state = jbba_pkg::ST_IDLE;
                end
            end
            default: n_state = jbba_pkg::ST_CLEAR;
        endcase
    end

    // state machine: outputs
    always_comb begin
        clr_active = 1'b0;
        issue_fire = 1'b0;
        issue_last = (r_mode == jbba_pkg::MODE_READ) ||
                     (r_k == jbba_pkg::INFL_W'(jbba_pkg::INFLUENCES - 1));
        i_in.ready = 1'b0;
        unique case (r_state)
            jbba_pkg::ST_CLEAR: begin
                clr_active = 1'b1;
            end
            jbba_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            jbba_pkg::ST_WORK: begin
                issue_fire = (r_mode == jbba_pkg::MODE_ACCUM) || out_free;
                i_in.ready = issue_fire && issue_last;
            end
            default: begin
                clr_active = 1'b0;
            end
        endcase
    end

    assign in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= jbba_pkg::ST_CLEAR;
            r_clr_idx <= '0;
            r_k       <= '0;
        end else begin
            r_state <= n_state;
            if (clr_active) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (in_fire) begin
                r_k <= '0;
            end else if (issue_fire && !issue_last) begin
                r_k <= r_k + jbba_pkg::INFL_W'(1);
            end
        end
    end

    // held beat
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode      <= i_in.mode;
            r_pos_x     <= i_in.pos_x;
            r_pos_y     <= i_in.pos_y;
            r_pos_z     <= i_in.pos_z;
            r_joint[0]  <= i_in.joint_a;
            r_joint[1]  <= i_in.joint_b;
            r_joint[2]  <= i_in.joint_c;
            r_joint[3]  <= i_in.joint_d;
            r_weight[0] <= i_in.weight_a;
            r_weight[1] <= i_in.weight_b;
            r_weight[2] <= i_in.weight_c;
            r_weight[3] <= i_in.weight_d;
        end
    end

    // store read
    assign ram_re = issue_fire &&
                    ((r_mode == jbba_pkg::MODE_READ) ? store_hit : acc_take);

    // update stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue_fire && ((r_mode == jbba_pkg::MODE_READ) || acc_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_fire) begin
            r_s1_read <= r_mode;
            r_s1_hit  <= store_hit;
            r_s1_addr <= sel_joint[IDX_W-1:0];
            r_s1_x    <= r_pos_x;
            r_s1_y    <= r_pos_y;
            r_s1_z    <= r_pos_z;
        end
    end

    // read-modify-write
    assign fwd_hit = r_fwd_valid && (r_fwd_addr == r_s1_addr);
    assign cur     = fwd_hit ? r_fwd_data : t_entry'(ram_rdata);
    assign s1_wr   = r_s1_valid && (!r_s1_read || r_s1_hit);

    always_comb begin
        s1_new = cur;
        if (r_s1_read) begin
            s1_new.filled = 1'b0;
        end else if (!cur.filled) begin
            s1_new.filled = 1'b1;
            s1_new.lo_x   = r_s1_x;
            s1_new.lo_y   = r_s1_y;
            s1_new.lo_z   = r_s1_z;
            s1_new.hi_x   = r_s1_x;
            s1_new.hi_y   = r_s1_y;
            s1_new.hi_z   = r_s1_z;
        end else begin
            if (r_s1_x < cur.lo_x) s1_new.lo_x = r_s1_x;
            if (r_s1_y < cur.lo_y) s1_new.lo_y = r_s1_y;
            if (r_s1_z < cur.lo_z) s1_new.lo_z = r_s1_z;
            if (r_s1_x > cur.hi_x) s1_new.hi_x = r_s1_x;
            if (r_s1_y > cur.hi_y) s1_new.hi_y = r_s1_y;
            if (r_s1_z > cur.hi_z) s1_new.hi_z = r_s1_z;
        end
    end

    always_comb begin
        out_next = '0;
        if (r_s1_hit && cur.filled) begin
            out_next = cur;
        end
    end

    // write port: clearing pass, then write-back
    assign ram_we    = clr_active || s1_wr;
    assign ram_waddr = clr_active ? r_clr_idx : r_s1_addr;
    assign ram_wdata = clr_active ? '0 : ENTRY_W'(s1_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= s1_wr && !clr_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= s1_new;
        end
    end

    jbba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (JOINTS_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (sel_joint[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && r_s1_read) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_read) begin
            r_out <= out_next;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.box_valid = r_out.filled;
    assign o_out.min_x     = r_out.lo_x;
    assign o_out.min_y     = r_out.lo_y;
    assign o_out.min_z     = r_out.lo_z;
    assign o_out.max_x     = r_out.hi_x;
    assign o_out.max_y     = r_out.hi_y;
    assign o_out.max_z     = r_out.hi_z;

    `JBBA_ASSERT_NOW(a_no_beat_in_clear, r_state == jbba_pkg::ST_CLEAR, !i_in.ready, "beat taken during clearing pass")
    `JBBA_ASSERT_NOW(a_out_not_overrun, r_s1_valid && r_s1_read, !r_out_valid, "read result would overwrite a pending box")
    `JBBA_ASSERT_NEXT(a_clear_quiet, r_state == jbba_pkg::ST_CLEAR, !r_s1_valid, "update stage busy during clearing pass")

endmodule
